@@ src/open_address_hash_set_macros.svh @@
// Assertion helpers shared by the hash set modules.
// All of them sample on clk_i and are off while rst_ni is low.
`ifndef OPEN_ADDRESS_HASH_SET_MACROS_SVH
`define OPEN_ADDRESS_HASH_SET_MACROS_SVH

// Plain property that must hold at every edge
`define OHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define OHS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define OHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ohs_pkg.sv @@
`default_nettype none

package ohs_pkg;

  // Operation carried on the input tuser
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  // Key bits folded into the home-slot residue per cycle
  localparam int DIGIT_BITS = 4;

  // Entries between the hashing front and the probing back
  localparam int QUEUE_DEPTH = 2;

  // Result word: found in bit 0, table_full in bit 1, zero padded
  localparam int OUT_TDATA_W = 8;

endpackage

`default_nettype wire

@@ src/ohs_front.sv @@
`default_nettype none

module ohs_front #(
  parameter int PRIME_MOD   = 1021,
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BITS    = 40,
  localparam int SlotW      = $clog2(PRIME_MOD),
  localparam int IdxW       = $clog2(TABLE_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input word
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_op_i,
  input  logic [KEY_BITS-1:0] in_key_i,
  // back end finished its clearing pass
  input  logic                clear_done_i,
  // queue write side
  input  logic                q_full_i,
  output logic                q_push_o,
  output logic                q_op_o,
  output logic                q_bypass_o,
  output logic [KEY_BITS-1:0] q_tag_o,
  output logic [SlotW-1:0]    q_slot_o,
  output logic [IdxW-1:0]     q_idx_o
);
  import ohs_pkg::*;

  localparam int AccW       = ((SlotW > IdxW) ? SlotW : IdxW) + 1;
  localparam int NumKeyDig  = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int KeyPadW    = NumKeyDig * DIGIT_BITS;
  localparam int NumSlotDig = (SlotW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int SlotPadW   = NumSlotDig * DIGIT_BITS;
  localparam int MaxDig     = (NumKeyDig > NumSlotDig) ? NumKeyDig : NumSlotDig;
  localparam int CntW       = $clog2(MaxDig);
  localparam bit NeedWrap   = TABLE_DEPTH < PRIME_MOD;

  localparam logic [AccW-1:0] ModHash = AccW'(PRIME_MOD - 1);
  localparam logic [AccW-1:0] ModIdx  = AccW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_HASH = 4'b0010,
    F_WRAP = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_e;

  // Fold one digit into a residue, msb first; acc stays below md
  function automatic logic [AccW-1:0] red_digit(input logic [AccW-1:0]       acc,
                                                input logic [DIGIT_BITS-1:0] dig,
                                                input logic [AccW-1:0]       md);
    logic [AccW-1:0] t;
    t = acc;
    for (int i = DIGIT_BITS - 1; i >= 0; i--) begin
      t = {t[AccW-2:0], dig[i]};
      if (t >= md) begin
        t = t - md;
      end
    end
    return t;
  endfunction

  front_state_e          state_q, state_d;
  logic                  op_q;
  logic                  bypass_q;
  logic [KEY_BITS-1:0]   tag_q;
  logic [KeyPadW-1:0]    key_sh_q;
  logic [SlotPadW-1:0]   slot_sh_q;
  logic [AccW-1:0]       acc_q;
  logic [CntW-1:0]       cnt_q;
  logic [SlotW-1:0]      slot_q;
  logic [IdxW-1:0]       idx_q;

  logic                  accept;
  logic                  wrap_phase;
  logic [DIGIT_BITS-1:0] digit;
  logic [AccW-1:0]       acc_next;
  logic [SlotW-1:0]      home_slot;

  // Residue step: key mod (P-1) while hashing, home slot mod depth while wrapping
  assign wrap_phase = (state_q == F_WRAP);
  assign digit      = wrap_phase ? slot_sh_q[SlotPadW-1 -: DIGIT_BITS]
                                 : key_sh_q[KeyPadW-1 -: DIGIT_BITS];
  assign acc_next   = red_digit(acc_q, digit, wrap_phase ? ModIdx : ModHash);
  assign home_slot  = acc_next[SlotW-1:0] + SlotW'(1);

  assign in_ready_o = (state_q == F_IDLE) && clear_done_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = (state_q == F_PUSH) && !q_full_i;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = (in_key_i == '1) ? F_PUSH : F_HASH;
        end
      end
      F_HASH: begin
        if (cnt_q == '0) begin
          state_d = NeedWrap ? F_WRAP : F_PUSH;
        end
      end
      F_WRAP: begin
        if (cnt_q == '0) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          op_q     <= in_op_i;
          bypass_q <= (in_key_i == '1);
          tag_q    <= in_key_i + KEY_BITS'(1);
          key_sh_q <= KeyPadW'(in_key_i);
          acc_q    <= '0;
          cnt_q    <= CntW'(NumKeyDig - 1);
          slot_q   <= '0;
          idx_q    <= '0;
        end
      end
      F_HASH: begin
        key_sh_q <= key_sh_q << DIGIT_BITS;
        if (cnt_q == '0) begin
          slot_q    <= home_slot;
          slot_sh_q <= SlotPadW'(home_slot);
          idx_q     <= IdxW'(home_slot);
          acc_q     <= '0;
          cnt_q     <= CntW'(NumSlotDig - 1);
        end else begin
          acc_q <= acc_next;
          cnt_q <= cnt_q - CntW'(1);
        end
      end
      F_WRAP: begin
        acc_q     <= acc_next;
        slot_sh_q <= slot_sh_q << DIGIT_BITS;
        cnt_q     <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          idx_q <= acc_next[IdxW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign q_op_o     = op_q;
  assign q_bypass_o = bypass_q;
  assign q_tag_o    = tag_q;
  assign q_slot_o   = slot_q;
  assign q_idx_o    = idx_q;

endmodule

`default_nettype wire

@@ src/ohs_queue.sv @@
`default_nettype none
`include "open_address_hash_set_macros.svh"

module ohs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = entries_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  `OHS_ASSERT_IMPL(a_no_overflow, push_i, !full_o, "queue written while full")
  `OHS_ASSERT_IMPL(a_no_underflow, pop_i, valid_o, "queue read while empty")
  `OHS_ASSERT(a_cnt_bound, cnt_q <= CntW'(DEPTH), "queue level beyond depth")
  `OHS_ASSERT_NEXT(a_cnt_step, push_i && !pop_i, cnt_q == $past(cnt_q) + 1, "level missed a push")

endmodule

`default_nettype wire

@@ src/ohs_back.sv @@
`default_nettype none
`include "open_address_hash_set_macros.svh"

module ohs_back #(
  parameter int PRIME_MOD   = 1021,
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BITS    = 40,
  localparam int SlotW      = $clog2(PRIME_MOD),
  localparam int IdxW       = $clog2(TABLE_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // queue read side
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  logic                q_op_i,
  input  logic                q_bypass_i,
  input  logic [KEY_BITS-1:0] q_tag_i,
  input  logic [SlotW-1:0]    q_slot_i,
  input  logic [IdxW-1:0]     q_idx_i,
  // table ready after reset
  output logic                clear_done_o,
  // result word
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic                m_found_o,
  output logic                m_full_o
);
  import ohs_pkg::*;

  localparam int SlotXW = SlotW + 1;
  localparam int IdxXW  = IdxW + 2;

  localparam logic [SlotW-1:0]  LastProbe = SlotW'(PRIME_MOD - 2);
  localparam logic [SlotXW-1:0] PrimeExt  = SlotXW'(PRIME_MOD);
  localparam logic [IdxXW-1:0]  IdxAdj    = IdxXW'(TABLE_DEPTH - (PRIME_MOD % TABLE_DEPTH));
  localparam logic [IdxXW-1:0]  DepthExt  = IdxXW'(TABLE_DEPTH);
  localparam logic [IdxXW-1:0]  Depth2    = IdxXW'(2 * TABLE_DEPTH);
  localparam logic [IdxW-1:0]   ClrLast   = IdxW'(TABLE_DEPTH - 1);

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001,
    B_IDLE  = 5'b00010,
    B_READ  = 5'b00100,
    B_CHECK = 5'b01000,
    B_DONE  = 5'b10000
  } back_state_e;

  back_state_e         state_q, state_d;
  logic [IdxW-1:0]     clr_q;
  op_e                 op_q;
  logic [KEY_BITS-1:0] tag_q;
  logic [SlotW-1:0]    slot_q;
  logic [IdxW-1:0]     idx_q;
  logic [SlotW-1:0]    probes_q;
  logic                res_found_q, res_full_q;
  logic                out_valid_q;
  logic                out_found_q, out_full_q;

  logic [KEY_BITS-1:0] slot_store_q [TABLE_DEPTH];
  logic [KEY_BITS-1:0] rdata_q;
  logic                mem_we, mem_re;
  logic [IdxW-1:0]     mem_addr;
  logic [KEY_BITS-1:0] mem_wdata;

  logic                held_empty, held_hit, last_probe;
  logic                load_out;
  logic [SlotXW-1:0]   slot_dbl, slot_sub;
  logic                slot_wrap;
  logic [SlotW-1:0]    slot_nx;
  logic [IdxXW-1:0]    idx_sum;
  logic [IdxW-1:0]     idx_nx;

  // Next probe: slot doubles mod P, index follows mod depth
  assign slot_dbl  = {slot_q, 1'b0};
  assign slot_wrap = (slot_dbl >= PrimeExt);
  assign slot_sub  = slot_dbl - PrimeExt;
  assign slot_nx   = slot_wrap ? slot_sub[SlotW-1:0] : slot_dbl[SlotW-1:0];
  assign idx_sum   = {1'b0, idx_q, 1'b0} + (slot_wrap ? IdxAdj : '0);

  always_comb begin
    logic [IdxXW-1:0] v;
    v = idx_sum;
    if (v >= Depth2) begin
      v = v - Depth2;
    end else if (v >= DepthExt) begin
      v = v - DepthExt;
    end
    idx_nx = v[IdxW-1:0];
  end

  // Slot compare
  assign held_empty = (rdata_q == '0);
  assign held_hit   = (rdata_q == tag_q);
  assign last_probe = (probes_q == LastProbe);

  // Table port: clearing sweep, probe read, insert write
  assign mem_re    = (state_q == B_READ);
  assign mem_we    = (state_q == B_CLEAR) ||
                     ((state_q == B_CHECK) && held_empty && (op_q == OP_INSERT));
  assign mem_addr  = (state_q == B_CLEAR) ? clr_q : idx_q;
  assign mem_wdata = (state_q == B_CLEAR) ? '0 : tag_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_store_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= slot_store_q[mem_addr];
    end
  end

  assign q_pop_o      = (state_q == B_IDLE) && q_valid_i;
  assign load_out     = (state_q == B_DONE) && (!out_valid_q || m_ready_i);
  assign clear_done_o = (state_q != B_CLEAR);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: begin
        if (clr_q == ClrLast) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid_i) begin
          state_d = q_bypass_i ? B_DONE : B_READ;
        end
      end
      B_READ:  state_d = B_CHECK;
      B_CHECK: begin
        if (held_empty || held_hit || last_probe) begin
          state_d = B_DONE;
        end else begin
          state_d = B_READ;
        end
      end
      B_DONE: begin
        if (load_out) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_q <= clr_q + IdxW'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Probe registers and result
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      op_q        <= op_e'(q_op_i);
      tag_q       <= q_tag_i;
      slot_q      <= q_slot_i;
      idx_q       <= q_idx_i;
      probes_q    <= '0;
      res_found_q <= 1'b0;
      res_full_q  <= 1'b0;
    end
    if (state_q == B_CHECK && !held_empty) begin
      if (held_hit) begin
        res_found_q <= 1'b1;
      end else if (last_probe) begin
        res_full_q <= 1'b1;
      end else begin
        probes_q <= probes_q + SlotW'(1);
        slot_q   <= slot_nx;
        idx_q    <= idx_nx;
      end
    end
    if (load_out) begin
      out_found_q <= res_found_q;
      out_full_q  <= res_full_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_found_o = out_found_q;
  assign m_full_o  = out_full_q;

  `OHS_ASSERT_IMPL(a_pop_after_clear, q_pop_o, clear_done_o, "word taken during clear")
  `OHS_ASSERT_IMPL(a_result_excl, out_valid_q, !(out_found_q && out_full_q), "found and full")
  `OHS_ASSERT_IMPL(a_probe_bound, state_q == B_CHECK, probes_q <= LastProbe, "probe overrun")
  `OHS_ASSERT_IMPL(a_write_empty, mem_we && state_q == B_CHECK, rdata_q == '0, "overwrote a key")

endmodule

`default_nettype wire

@@ src/open_address_hash_set.sv @@
// Flow: the front hashes the key a digit at a time (and folds the home slot when
// TABLE_DEPTH < PRIME_MOD), the word passes the work queue, the back reads and checks
// one slot per probe and the result register holds the answer; an all-ones key
// skips hashing and probing. The front takes no new word until the last is pushed;
// the back handles one word at a time, limited by the one-port slot table.
// Reset: a clearing pass empties the table; s_axis_tready stays low.
`default_nettype none

module open_address_hash_set #(
  parameter int PRIME_MOD   = 1021,
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BITS    = 40
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((KEY_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // key
  input  logic                                 s_axis_tuser,  // operation
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [ohs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata   // found, table_full
);
  import ohs_pkg::*;

  localparam int SlotW  = $clog2(PRIME_MOD);
  localparam int IdxW   = $clog2(TABLE_DEPTH);
  localparam int EntryW = 2 + KEY_BITS + SlotW + IdxW;

  logic                q_push, q_full, q_pop, q_valid;
  logic                f_op, f_bypass, b_op, b_bypass;
  logic [KEY_BITS-1:0] f_tag, b_tag;
  logic [SlotW-1:0]    f_slot, b_slot;
  logic [IdxW-1:0]     f_idx, b_idx;
  logic [EntryW-1:0]   q_wdata, q_rdata;
  logic                clear_done;
  logic                res_found, res_full;

  // Hash front
  ohs_front #(
    .PRIME_MOD  (PRIME_MOD),
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_key_i    (s_axis_tdata[KEY_BITS-1:0]),
    .clear_done_i(clear_done),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_op_o      (f_op),
    .q_bypass_o  (f_bypass),
    .q_tag_o     (f_tag),
    .q_slot_o    (f_slot),
    .q_idx_o     (f_idx)
  );

  // Work queue
  assign q_wdata = {f_op, f_bypass, f_tag, f_slot, f_idx};

  ohs_queue #(
    .WIDTH(EntryW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  assign {b_op, b_bypass, b_tag, b_slot, b_idx} = q_rdata;

  // Probe back end and slot table
  ohs_back #(
    .PRIME_MOD  (PRIME_MOD),
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_op_i      (b_op),
    .q_bypass_i  (b_bypass),
    .q_tag_i     (b_tag),
    .q_slot_i    (b_slot),
    .q_idx_i     (b_idx),
    .clear_done_o(clear_done),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_found_o   (res_found),
    .m_full_o    (res_full)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - 2)'(0), res_full, res_found};

endmodule

`default_nettype wire
